>>> design/bic_pkg.sv
// ----------------------------------------------------------------------------
// bic_pkg
// Shared widths, codes and helpers for the Butterworth IIR cascade unit.
// ----------------------------------------------------------------------------
package bic_pkg;

  localparam int MAX_PAIRS       = 4;
  localparam int SAMPLE_BITS     = 16;
  localparam int COEF_FRAC_BITS  = 15;
  localparam int STATE_FRAC_BITS = 8;

  localparam int COEF_BITS    = COEF_FRAC_BITS + 3;
  localparam int STATE_BITS   = SAMPLE_BITS + STATE_FRAC_BITS;
  localparam int NUM_SECTIONS = MAX_PAIRS + 1;
  localparam int NUM_COEFS    = 2 + 3 * MAX_PAIRS;

  localparam int SEC_W     = $clog2(NUM_SECTIONS);
  localparam int COEF_AW   = $clog2(NUM_COEFS);
  localparam int OPND_BITS = STATE_BITS + 3;
  localparam int PROD_BITS = COEF_BITS + OPND_BITS;
  localparam int ACC_BITS  = PROD_BITS + 1;

  localparam int POLE_BITS = 4;
  localparam int CFG_BITS  = POLE_BITS;
  localparam int CFG_AW    = 1;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_FILTER_MODE = 1'd0;
  localparam logic [CFG_AW-1:0] REG_POLE_COUNT  = 1'd1;

  // input word opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC_RD,
    ST_LOAD,
    ST_TERM,
    ST_DRAIN,
    ST_WB,
    ST_OUT
  } bic_state_t;

  // one delay memory row: the past inputs and outputs of a section
  typedef struct packed {
    logic signed [STATE_BITS-1:0] in1;
    logic signed [STATE_BITS-1:0] in2;
    logic signed [STATE_BITS-1:0] out1;
    logic signed [STATE_BITS-1:0] out2;
  } dly_row_t;

  // first coefficient address of a section
  function automatic logic [COEF_AW-1:0] coef_base(input logic [SEC_W-1:0] sec);
    logic [COEF_AW-1:0] base;
    if (sec == '0) begin
      base = '0;
    end else begin
      base = COEF_AW'(3 * int'(sec) - 1);
    end
    return base;
  endfunction

endpackage

>>> design/butterworth_iir_cascade_unit.sv
// ----------------------------------------------------------------------------
// butterworth_iir_cascade_unit
// Butterworth low/high-pass cascade: optional first-order section plus up to
// four biquads, one shared multiply-accumulate, state held in memories.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready): each word either writes one Q3.15
//   coefficient (opcode 1, no result) or filters one sample (opcode 0, one
//   result). start_of_trace on a sample word clears all section delays first.
// - output channel (out_valid/out_ready): sample_out with its saturated flag.
// - cfg_write/cfg_index/cfg_data set filter_mode and pole_count; write them
//   only while the unit is idle.
// Sequence:
// - a coefficient word is written while the unit stays idle.
// - a sample word runs the first-order section (odd pole count), then each
//   biquad, then the output state; the shared multiplier walks the terms of
//   each section one per cycle, and each reads and writes its delay row once.
// - in_ready is high only between samples; a new word is taken while the
//   last result still waits on the output register.
// Reset: coefficients and delays read as zero, both registers clear to zero.
// Stall: if out_ready stays low, the next finished sample waits in the final
//   state until the output register frees up, and no word is taken meanwhile.
// ----------------------------------------------------------------------------
module butterworth_iir_cascade_unit (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_write,
  input  logic [bic_pkg::CFG_AW-1:0]                 cfg_index,
  input  logic [bic_pkg::CFG_BITS-1:0]               cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       opcode,
  input  logic                                       start_of_trace,
  input  logic signed [bic_pkg::SAMPLE_BITS-1:0]     sample_in,
  input  logic [bic_pkg::COEF_AW-1:0]                coef_index,
  input  logic signed [bic_pkg::COEF_BITS-1:0]       coef_value,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [bic_pkg::SAMPLE_BITS-1:0]     sample_out,
  output logic                                       saturated
);
  import bic_pkg::*;

  localparam logic signed [ACC_BITS-1:0] ROUND_ACC =
    ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [STATE_BITS:0] ROUND_OUT =
    (STATE_BITS + 1)'(1) <<< (STATE_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [STATE_BITS-1:0]  ST_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0]  ST_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};

  // configuration registers
  logic                 filter_mode;
  logic [POLE_BITS-1:0] pole_count;

  // control
  bic_state_t              state, state_next;
  logic [SEC_W-1:0]        sec;
  logic [1:0]              t;
  logic [NUM_SECTIONS-1:0] dly_valid;
  logic [NUM_COEFS-1:0]    coef_valid;
  logic                    prod_vld;
  logic                    prod_first;

  // memories
  logic signed [COEF_BITS-1:0] coef_mem [NUM_COEFS];
  dly_row_t                    dly_mem  [NUM_SECTIONS];

  // read data
  logic signed [COEF_BITS-1:0] coef_q;
  logic                        coef_vq;
  dly_row_t                    row_q;
  logic                        row_vq;

  // datapath
  logic signed [STATE_BITS-1:0] v;
  logic                         sat;
  logic signed [STATE_BITS-1:0] hold_in1;
  logic signed [STATE_BITS-1:0] hold_out1;
  logic signed [OPND_BITS-1:0]  op0, op1, op2;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [ACC_BITS-1:0]   acc;

  // strobes from the sequencer
  logic dly_rd, coef_rd, ops_load, mac_en, dly_wr, out_load;

  logic                   in_fire, sample_fire, coef_fire;
  logic [SEC_W-1:0]       pairs;
  logic [1:0]             last_t;
  logic [COEF_AW-1:0]     coef_addr;
  dly_row_t               row_eff;
  logic signed [COEF_BITS-1:0] coef_eff;
  logic signed [OPND_BITS-1:0] opnd;
  logic signed [OPND_BITS-1:0] p_x, p1_x, p2_x, d;
  logic signed [ACC_BITS-1:0]  acc_rnd;
  logic signed [ACC_BITS-COEF_FRAC_BITS-1:0] acc_sh;
  logic signed [STATE_BITS-1:0] y;
  logic                         y_clip;
  logic signed [STATE_BITS:0]   r_rnd;
  logic signed [SAMPLE_BITS:0]  r_sh;
  logic signed [SAMPLE_BITS-1:0] r_out;
  logic                          r_clip;

  assign in_fire     = in_valid && in_ready;
  assign sample_fire = in_fire && (opcode == OP_SAMPLE);
  assign coef_fire   = in_fire && (opcode == OP_COEF);

  // biquad count, limited to the number of biquads built
  assign pairs  = (pole_count[POLE_BITS-1:1] > (POLE_BITS-1)'(MAX_PAIRS)) ?
                  SEC_W'(MAX_PAIRS) : SEC_W'(pole_count[POLE_BITS-1:1]);
  assign last_t = (sec == '0) ? 2'd1 : 2'd2;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_fire) begin
          if (pole_count[0] || (pairs != '0)) begin
            state_next = ST_SEC_RD;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SEC_RD: state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_TERM;
      ST_TERM: begin
        if (t == last_t) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_WB;
      ST_WB: begin
        if (sec < pairs) begin
          state_next = ST_SEC_RD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    in_ready = 1'b0;
    dly_rd   = 1'b0;
    coef_rd  = 1'b0;
    ops_load = 1'b0;
    mac_en   = 1'b0;
    dly_wr   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_SEC_RD: begin
        dly_rd  = 1'b1;
        coef_rd = 1'b1;
      end
      ST_LOAD:   ops_load = 1'b1;
      ST_TERM: begin
        mac_en  = 1'b1;
        coef_rd = (t != last_t);
      end
      ST_DRAIN:  ;
      ST_WB:     dly_wr = 1'b1;
      ST_OUT:    out_load = !out_valid || out_ready;
      default:   ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      filter_mode <= 1'b0;
      pole_count  <= '0;
      sec         <= '0;
      t           <= '0;
      dly_valid   <= '0;
      coef_valid  <= '0;
      prod_vld    <= 1'b0;
      prod_first  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FILTER_MODE: filter_mode <= cfg_data[0];
          REG_POLE_COUNT:  pole_count  <= cfg_data[POLE_BITS-1:0];
          default: ;
        endcase
      end
      if (coef_fire && (coef_index < COEF_AW'(NUM_COEFS))) begin
        coef_valid[coef_index] <= 1'b1;
      end
      // section walk
      if (sample_fire) begin
        sec <= pole_count[0] ? SEC_W'(0) : SEC_W'(1);
        if (start_of_trace) begin
          dly_valid <= '0;
        end
      end else if (dly_wr) begin
        dly_valid[sec] <= 1'b1;
        sec            <= sec + SEC_W'(1);
      end
      // term counter
      if (ops_load) begin
        t <= '0;
      end else if (mac_en) begin
        t <= t + 2'd1;
      end
      prod_vld   <= mac_en;
      prod_first <= mac_en && (t == 2'd0);
      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // coefficient memory
  assign coef_addr = coef_base(sec) + ((state == ST_SEC_RD) ? COEF_AW'(0) : COEF_AW'(t + 2'd1));

  always_ff @(posedge clk) begin
    if (coef_fire && (coef_index < COEF_AW'(NUM_COEFS))) begin
      coef_mem[coef_index] <= coef_value;
    end
    if (coef_rd) begin
      coef_q  <= coef_mem[coef_addr];
      coef_vq <= coef_valid[coef_addr];
    end
  end

  // delay memory
  always_ff @(posedge clk) begin
    if (dly_wr) begin
      dly_mem[sec] <= '{in1: v, in2: hold_in1, out1: y, out2: hold_out1};
    end
    if (dly_rd) begin
      row_q  <= dly_mem[sec];
      row_vq <= dly_valid[sec];
    end
  end

  assign row_eff  = row_vq ? row_q : '0;
  assign coef_eff = coef_vq ? coef_q : '0;

  // numerator term of the section
  assign p_x  = OPND_BITS'(v);
  assign p1_x = OPND_BITS'(row_eff.in1);
  assign p2_x = OPND_BITS'(row_eff.in2);
  always_comb begin
    if (sec == '0) begin
      d = filter_mode ? (p_x - p1_x) : (p_x + p1_x);
    end else begin
      d = filter_mode ? (p_x - (p1_x <<< 1) + p2_x) : (p_x + (p1_x <<< 1) + p2_x);
    end
  end

  always_comb begin
    unique case (t)
      2'd0:    opnd = op0;
      2'd1:    opnd = op1;
      default: opnd = op2;
    endcase
  end

  // rescale of the section sum
  assign acc_rnd = acc + ROUND_ACC;
  assign acc_sh  = acc_rnd[ACC_BITS-1:COEF_FRAC_BITS];
  always_comb begin
    y      = acc_sh[STATE_BITS-1:0];
    y_clip = 1'b0;
    if (acc_sh > (ACC_BITS-COEF_FRAC_BITS)'(ST_MAX)) begin
      y      = ST_MAX;
      y_clip = 1'b1;
    end else if (acc_sh < (ACC_BITS-COEF_FRAC_BITS)'(ST_MIN)) begin
      y      = ST_MIN;
      y_clip = 1'b1;
    end
  end

  // final rounding to the sample grid
  assign r_rnd = (STATE_BITS+1)'(v) + ROUND_OUT;
  assign r_sh  = r_rnd[STATE_BITS:STATE_FRAC_BITS];
  always_comb begin
    r_out  = r_sh[SAMPLE_BITS-1:0];
    r_clip = 1'b0;
    if (r_sh > (SAMPLE_BITS+1)'(OUT_MAX)) begin
      r_out  = OUT_MAX;
      r_clip = 1'b1;
    end else if (r_sh < (SAMPLE_BITS+1)'(OUT_MIN)) begin
      r_out  = OUT_MIN;
      r_clip = 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      v   <= {sample_in, {STATE_FRAC_BITS{1'b0}}};
      sat <= 1'b0;
    end else if (dly_wr) begin
      v   <= y;
      sat <= sat | y_clip;
    end
    if (ops_load) begin
      op0       <= d;
      op1       <= -OPND_BITS'(row_eff.out1);
      op2       <= -OPND_BITS'(row_eff.out2);
      hold_in1  <= row_eff.in1;
      hold_out1 <= row_eff.out1;
    end
    if (mac_en) begin
      prod <= coef_eff * opnd;
    end
    if (prod_vld) begin
      acc <= (prod_first ? ACC_BITS'(0) : acc) + ACC_BITS'(prod);
    end
    if (out_load) begin
      sample_out <= r_out;
      saturated  <= sat | r_clip;
    end
  end

endmodule
